// ===== rtl/fasta_reference_packer_defines.svh =====
// Assertion macros shared by the packer RTL.
// Each check samples on clk_i and is off while rst_ni is low.
`ifndef FASTA_REFERENCE_PACKER_DEFINES_SVH
`define FASTA_REFERENCE_PACKER_DEFINES_SVH

`ifndef SYNTH

// Property must hold at every clock edge out of reset
`define FRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frp assertion failed");

// Condition must never be true
`define FRP_ASSERT_NEVER(lbl, cond) \
  `FRP_ASSERT(lbl, !(cond))

`else

`define FRP_ASSERT(lbl, prop)
`define FRP_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/frp_pkg.sv =====
package frp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgNCode       = 2'd0;
  localparam logic [1:0] CfgUnknownCode = 2'd1;
  localparam logic [1:0] CfgStartPos    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [3:0] NCodeReset       = 4'd4;
  localparam logic [3:0] UnknownCodeReset = 4'd15;

  // Characters the parser reacts to
  localparam logic [7:0] ChMarker = 8'h3E;  // '>'
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChUpperN = 8'h4E;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChUpperC = 8'h43;
  localparam logic [7:0] ChLowerC = 8'h63;
  localparam logic [7:0] ChUpperG = 8'h47;
  localparam logic [7:0] ChLowerG = 8'h67;
  localparam logic [7:0] ChUpperT = 8'h54;
  localparam logic [7:0] ChLowerT = 8'h74;

  // Base codes for A, C, G, T
  localparam logic [3:0] CodeA = 4'd0;
  localparam logic [3:0] CodeC = 4'd1;
  localparam logic [3:0] CodeG = 4'd2;
  localparam logic [3:0] CodeT = 4'd3;

  // Output word packing
  localparam int unsigned OutDataBits = 168;

  typedef enum logic [2:0] {
    ModeExpect  = 3'd0,
    ModeHeader  = 3'd1,
    ModeLeading = 3'd2,
    ModeBody    = 3'd3,
    ModeError   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KindSymbol = 2'd0,
    KindDesc   = 2'd1,
    KindFileOk = 2'd2,
    KindError  = 2'd3
  } kind_e;

  // What the current input word does in this cycle
  typedef enum logic [3:0] {
    ActDrop,       // consumed, no result
    ActOpen,       // start a record, no result
    ActFail,       // missing marker: format error
    ActDescEof,    // descriptor before file ok
    ActFileOk,     // end of file
    ActCloseOpen,  // descriptor, then start next record
    ActEol,        // header done
    ActLeadN,      // count a leading N
    ActSep,        // one separator write
    ActSymbol      // symbol write
  } act_e;

  // Classification of one data byte
  typedef struct packed {
    logic       marker;
    logic       eol;
    logic       base_n;
    logic [3:0] code;
  } class_t;

  // One result word
  typedef struct packed {
    kind_e       kind;
    logic [31:0] write_address;
    logic [3:0]  symbol_code;
    logic [31:0] record_length;
    logic [31:0] record_origin;
    logic [31:0] leading_n_count;
    logic [31:0] trailing_n_count;
    logic        last_result;
  } result_t;

endpackage

// ===== rtl/fasta_reference_packer.sv =====
// Path: an accepted word waits in the input register; its result is then registered.
// Throughput: one input word per cycle while the result port is ready; a word that
//   yields several results holds the input register until its last result is written,
//   so the first base of a record stalls input for SEPARATOR_LENGTH separator writes.
// Reset (rst_ni low, asynchronous): parser expects a record marker, position
//   returns to zero, n_code and unknown_code return to 4 and 15.
`include "fasta_reference_packer_defines.svh"

module fasta_reference_packer #(
  parameter int unsigned SEPARATOR_LENGTH = 32,
  parameter int unsigned POSITION_BITS    = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
  input  logic                             s_axis_tuser,   // [0] req_type
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] write_address, [35:32] symbol_code, [67:36] record_length,
  // [99:68] record_origin, [131:100] leading_n_count,
  // [163:132] trailing_n_count, [167:164] zero
  output logic [frp_pkg::OutDataBits-1:0]  m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,   // [1:0] out_kind
  output logic                             m_axis_tlast    // last_result
);
  import frp_pkg::*;

  localparam int unsigned SeqW = $clog2(SEPARATOR_LENGTH + 2);
  localparam logic [SeqW-1:0] SeqLast = SeqW'(SEPARATOR_LENGTH);

  // Configuration. The start position is not stored; the position returns to zero
  // at reset, so a write to that index has no visible effect.
  logic [3:0] n_code_q, unknown_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_code_q       <= NCodeReset;
      unknown_code_q <= UnknownCodeReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgNCode) n_code_q <= cfg_wdata_i[3:0];
      if (cfg_index_i == CfgUnknownCode) unknown_code_q <= cfg_wdata_i[3:0];
    end
  end

  // Input register
  logic       in_valid_q;
  logic       in_eof_q;
  logic [7:0] in_byte_q;
  logic       consume;

  assign s_axis_tready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_eof_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  class_t cls;

  frp_classify u_classify (
    .data_byte_i    (in_byte_q),
    .n_code_i       (n_code_q),
    .unknown_code_i (unknown_code_q),
    .class_o        (cls)
  );

  // Parser state
  mode_e                   mode_q, mode_d;
  logic [SeqW-1:0]         seq_q, seq_d;
  logic [POSITION_BITS-1:0] wp_q, wp_d;
  logic [POSITION_BITS-1:0] base_q, base_d;
  logic [31:0]             body_q, body_d;
  logic [31:0]             lead_q, lead_d;
  logic [31:0]             tail_q, tail_d;
  logic [31:0]             trim_q, trim_d;   // body minus trailing N run

  // Output register
  logic    out_valid_q;
  result_t out_q, out_d;
  logic    out_free;
  logic    go;
  logic    emit;
  act_e    act;

  assign out_free = !out_valid_q || m_axis_tready;
  assign go       = in_valid_q && out_free;

  // Decide what the held word does this cycle
  always_comb begin
    act = ActDrop;
    priority if (mode_q == ModeError) begin
      act = ActDrop;
    end else if (mode_q == ModeExpect) begin
      act = (!in_eof_q && cls.marker) ? ActOpen : ActFail;
    end else if (in_eof_q) begin
      act = (mode_q == ModeBody && trim_q != '0 && seq_q == '0) ? ActDescEof : ActFileOk;
    end else if (mode_q == ModeHeader) begin
      act = cls.eol ? ActEol : ActDrop;
    end else if (cls.marker) begin
      act = (mode_q == ModeBody && trim_q != '0) ? ActCloseOpen : ActOpen;
    end else if (cls.eol) begin
      act = ActDrop;
    end else if (mode_q == ModeLeading && cls.base_n) begin
      act = ActLeadN;
    end else if (mode_q == ModeLeading && seq_q != SeqLast) begin
      act = ActSep;
    end else begin
      act = ActSymbol;
    end
  end

  assign emit = (act == ActFail) || (act == ActDescEof) || (act == ActFileOk) ||
                (act == ActCloseOpen) || (act == ActSep) || (act == ActSymbol);
  assign consume = go && (act != ActDescEof) && (act != ActSep);

  // Next state
  always_comb begin
    logic [POSITION_BITS-1:0] wp_adv;
    wp_adv = wp_q + POSITION_BITS'(trim_q);
    mode_d = mode_q;
    seq_d  = seq_q;
    wp_d   = wp_q;
    base_d = base_q;
    body_d = body_q;
    lead_d = lead_q;
    tail_d = tail_q;
    trim_d = trim_q;
    unique case (act)
      ActOpen, ActCloseOpen: begin
        if (act == ActCloseOpen) wp_d = wp_adv;
        base_d = (act == ActCloseOpen) ? wp_adv : wp_q;
        body_d = '0;
        lead_d = '0;
        tail_d = '0;
        trim_d = '0;
        mode_d = ModeHeader;
      end
      ActFail: mode_d = ModeError;
      ActDescEof: begin
        wp_d  = wp_adv;
        seq_d = SeqW'(1);
      end
      ActFileOk: begin
        mode_d = ModeExpect;
        seq_d  = '0;
      end
      ActEol:   mode_d = ModeLeading;
      ActLeadN: lead_d = lead_q + 32'd1;
      ActSep: begin
        wp_d  = wp_q + POSITION_BITS'(1);
        seq_d = seq_q + SeqW'(1);
      end
      ActSymbol: begin
        body_d = body_q + 32'd1;
        if (cls.code == n_code_q) begin
          tail_d = tail_q + 32'd1;
        end else begin
          tail_d = '0;
          trim_d = body_q + 32'd1;
        end
        mode_d = ModeBody;
        seq_d  = '0;
      end
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    out_d = '0;
    unique case (act)
      ActFail: begin
        out_d.kind        = KindError;
        out_d.last_result = 1'b1;
      end
      ActFileOk: begin
        out_d.kind        = KindFileOk;
        out_d.last_result = 1'b1;
      end
      ActDescEof, ActCloseOpen: begin
        out_d.kind             = KindDesc;
        out_d.record_length    = trim_q;
        out_d.record_origin    = 32'(base_q);
        out_d.leading_n_count  = lead_q;
        out_d.trailing_n_count = tail_q;
        out_d.last_result      = (act == ActCloseOpen);
      end
      ActSep: begin
        out_d.kind          = KindSymbol;
        out_d.write_address = 32'(wp_q);
        out_d.symbol_code   = n_code_q;
      end
      ActSymbol: begin
        out_d.kind          = KindSymbol;
        out_d.write_address = 32'(wp_q + POSITION_BITS'(body_q));
        out_d.symbol_code   = cls.code;
        out_d.last_result   = 1'b1;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeExpect;
      seq_q  <= '0;
      wp_q   <= '0;
      base_q <= '0;
      body_q <= '0;
      lead_q <= '0;
      tail_q <= '0;
      trim_q <= '0;
    end else if (go) begin
      mode_q <= mode_d;
      seq_q  <= seq_d;
      wp_q   <= wp_d;
      base_q <= base_d;
      body_q <= body_d;
      lead_q <= lead_d;
      tail_q <= tail_d;
      trim_q <= trim_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= go && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last_result;
  assign m_axis_tdata  = {4'd0, out_q.trailing_n_count, out_q.leading_n_count,
                          out_q.record_origin, out_q.record_length,
                          out_q.symbol_code, out_q.write_address};

  // Checks
  `FRP_ASSERT_NEVER(a_quiet_after_error, go && emit && mode_q == ModeError)
  `FRP_ASSERT_NEVER(a_seq_bound, mode_q == ModeLeading && seq_q > SeqLast)
  `FRP_ASSERT(a_desc_nonzero, (go && emit && out_d.kind == KindDesc) |-> (trim_q != '0))
  `FRP_ASSERT(a_hold_input, (in_valid_q && !consume) |-> !s_axis_tready)
  `FRP_ASSERT(a_sep_not_last, (go && act == ActSep) |=> (out_valid_q && !m_axis_tlast))

endmodule

// ===== rtl/frp_classify.sv =====
module frp_classify (
  input  logic [7:0]      data_byte_i,
  input  logic [3:0]      n_code_i,
  input  logic [3:0]      unknown_code_i,
  output frp_pkg::class_t class_o
);
  import frp_pkg::*;

  logic [3:0] code;

  // Byte flags
  assign class_o.marker = (data_byte_i == ChMarker);
  assign class_o.eol    = (data_byte_i == ChLf) || (data_byte_i == ChCr);
  assign class_o.base_n = (data_byte_i == ChUpperN) || (data_byte_i == ChLowerN);

  // Nucleotide code map
  always_comb begin
    unique case (data_byte_i)
      ChUpperA, ChLowerA: code = CodeA;
      ChUpperC, ChLowerC: code = CodeC;
      ChUpperG, ChLowerG: code = CodeG;
      ChUpperT, ChLowerT: code = CodeT;
      ChUpperN, ChLowerN: code = n_code_i;
      default:            code = unknown_code_i;
    endcase
  end

  assign class_o.code = code;

endmodule
